### design/empm_pkg.sv
// Shared types, codes and constants of the expanded memory page mapper.
package empm_pkg;

    localparam int WINDOWS     = 4;
    localparam int WIN_W       = 2;
    localparam int PAGE_BYTES  = 16384;
    localparam int OFFSET_W    = 14;
    localparam int HANDLES_DEF = 255;
    localparam int MAX_PAGES_DEF = 2048;
    localparam int FRAME_SEG_RESET = 57344;
    localparam logic [15:0] UNMAP_PAGE = 16'hffff;
    localparam int IN_W  = 80;
    localparam int OUT_W = 72;

    typedef enum logic [2:0] {
        OP_ACCESS  = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_MAP     = 3'd3,
        OP_SAVE    = 3'd4,
        OP_RESTORE = 3'd5,
        OP_REALLOC = 3'd6,
        OP_QUERY   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NO_HANDLE   = 4'd1,
        ST_CTX_SAVED   = 4'd2,
        ST_OVER_TOTAL  = 4'd3,
        ST_OVER_FREE   = 4'd4,
        ST_ZERO        = 4'd5,
        ST_EXHAUSTED   = 4'd6,
        ST_BAD_LOGICAL = 4'd7,
        ST_BAD_WINDOW  = 4'd8,
        ST_SAVE_USED   = 4'd9,
        ST_SAVE_UNUSED = 4'd10
    } status_t;

    localparam logic CFG_FRAME_SEGMENT = 1'b0;
    localparam logic CFG_TOTAL_PAGES   = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [7:0]  handle;
        logic [10:0] page;
    } win_t;

    typedef struct packed {
        logic                in_frame;
        logic [WIN_W-1:0]    win;
        logic [OFFSET_W-1:0] offset;
    } dec_t;

endpackage

### design/empm_decode.sv
// Page frame address decoder: frame hit, window index and page offset.
module empm_decode (
    input  logic [15:0]       frame_segment,
    input  logic [19:0]       address,
    output empm_pkg::dec_t    dec
);
    logic [20:0] base;
    logic [20:0] top;
    logic [20:0] off;

    assign base = {1'b0, frame_segment, 4'b0000};
    assign top  = base + 21'h10000;
    assign off  = {1'b0, address} - base;

    assign dec.in_frame = ({1'b0, address} >= base) && ({1'b0, address} < top);
    assign dec.win      = off[15:14];
    assign dec.offset   = off[13:0];
endmodule

### design/expanded_memory_page_mapper_core.sv
// Top level of the expanded memory page mapper: handle table, windows and sequencer.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata  80 bits, one request
//  m_      | out       | m_tvalid/m_tready  | m_tdata  72 bits, one result
//  cfg_    | in        | cfg_we             | cfg_addr, cfg_wdata 16 bits
//
// An access goes through execute and, for a mapped window, a size lookup state; a query,
// map or failed command goes from execute to the result. Allocate scans the handle flags
// eight per cycle; the window check reads the size memory once per window; save and
// restore move four entries of the saved context memory. Reset clears all handle flags at
// once, no sweep. A result waits in the output register while the next request is taken.
module expanded_memory_page_mapper_core #(
    parameter int HANDLES   = empm_pkg::HANDLES_DEF,
    parameter int MAX_PAGES = empm_pkg::MAX_PAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // op[2:0], address[22:3], handle_in[38:23], logical_page[54:39],
    // window[62:55], page_count[78:63], zero pad [79]
    input  logic [empm_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[3:0], in_frame[4], mapped[5], target_handle[13:6], target_page[24:14],
    // page_offset[38:25], handle_pages[50:39], free_pages[62:51], handle_count[71:63]
    output logic [empm_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [15:0]               cfg_wdata
);
    localparam int HW  = (HANDLES > 1) ? $clog2(HANDLES) : 1;
    localparam int NCH = (HANDLES + 7) / 8;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * 8;
    localparam int TOTAL_RESET = (MAX_PAGES < 2048) ? MAX_PAGES : 2048;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_ACC, S_SCAN, S_CHK_RD, S_CHK_CMP,
        S_SAVE, S_RST_RD, S_RST_WR, S_DONE
    } state_t;

    state_t state_reg;
    logic [15:0] frame_segment_reg;
    logic [11:0] total_pages_reg;
    logic [11:0] pages_free_reg;
    logic [7:0]  open_handles_reg;
    logic [HANDLES-1:0] in_use_reg;
    logic [HANDLES-1:0] ctx_reg;
    empm_pkg::win_t wm_reg [empm_pkg::WINDOWS];

    logic [2:0]  op_reg;
    logic [19:0] addr_reg;
    logic [15:0] lp_reg;
    logic [7:0]  win_reg;
    logic [15:0] cnt_reg;
    logic        k_ok_reg;
    logic [HW-1:0] k_reg;
    logic [1:0]  wc_reg;
    logic [CW-1:0] chunk_reg;

    logic [3:0]  r_status_reg;
    logic        r_in_frame_reg;
    logic        r_mapped_reg;
    logic [7:0]  r_thandle_reg;
    logic [10:0] r_tpage_reg;
    logic [13:0] r_poff_reg;
    logic [11:0] r_hpages_reg;

    logic        m_tvalid_reg;
    logic [empm_pkg::OUT_W-1:0] m_tdata_reg;

    logic [11:0] size_mem [HANDLES];
    logic [11:0] size_rd;
    logic [HW-1:0] size_raddr;
    logic        size_we;
    logic [HW-1:0] size_waddr;
    logic [11:0] size_wdata;

    empm_pkg::win_t sav_mem [HANDLES*empm_pkg::WINDOWS];
    empm_pkg::win_t sav_rd;
    logic        sav_we;

    empm_pkg::dec_t dec;

    logic [15:0] s_hin;
    logic [15:0] s_hm1;
    logic        s_k_ok;
    logic [7:0]  acc_h;
    logic [7:0]  chk_h;
    logic [7:0]  acc_hm1;
    logic [7:0]  chk_hm1;
    logic        acc_h_ok;
    logic        chk_h_ok;
    logic [PADW-1:0] pad_use;
    logic [7:0]  chunk_bits;
    logic        chunk_free;
    logic [2:0]  chunk_pos;
    logic [HW-1:0] alloc_n;
    logic [12:0] avail;
    logic        realloc_go;
    logic [11:0] cfg_total;

    empm_decode u_decode (
        .frame_segment(frame_segment_reg),
        .address(addr_reg),
        .dec(dec)
    );

    assign s_hin  = s_tdata[38:23];
    assign s_hm1  = s_hin - 16'd1;
    assign s_k_ok = (s_hin != 16'd0) && (s_hin <= 16'(HANDLES)) && in_use_reg[s_hm1[HW-1:0]];

    assign acc_h    = wm_reg[dec.win].handle;
    assign acc_hm1  = acc_h - 8'd1;
    assign acc_h_ok = (acc_h != 8'd0) && (acc_h <= 8'(HANDLES)) && in_use_reg[acc_hm1[HW-1:0]];
    assign chk_h    = wm_reg[wc_reg].handle;
    assign chk_hm1  = chk_h - 8'd1;
    assign chk_h_ok = (chk_h != 8'd0) && (chk_h <= 8'(HANDLES)) && in_use_reg[chk_hm1[HW-1:0]];

    // Unused pad positions read as taken so the scan never picks them.
    assign pad_use    = {{(PADW-HANDLES){1'b1}}, in_use_reg};
    assign chunk_bits = pad_use[chunk_reg*8 +: 8];

    always_comb begin
        chunk_free = 1'b0;
        chunk_pos  = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!chunk_bits[i]) begin
                chunk_free = 1'b1;
                chunk_pos  = 3'(i);
            end
        end
    end

    assign alloc_n = HW'({chunk_reg, chunk_pos});
    assign avail   = {1'b0, pages_free_reg} + {1'b0, size_rd};
    assign realloc_go = (op_reg == empm_pkg::OP_REALLOC) && k_ok_reg
                        && (cnt_reg != {4'd0, size_rd})
                        && (cnt_reg <= {4'd0, total_pages_reg})
                        && (cnt_reg <= {3'd0, avail});
    assign cfg_total = (32'(cfg_wdata[11:0]) > MAX_PAGES) ? 12'(MAX_PAGES) : cfg_wdata[11:0];

    always_comb begin
        unique case (state_reg)
            S_IDLE:   size_raddr = s_hm1[HW-1:0];
            S_EXEC:   size_raddr = acc_hm1[HW-1:0];
            S_CHK_RD: size_raddr = chk_hm1[HW-1:0];
            default:  size_raddr = k_reg;
        endcase
    end

    always_comb begin
        size_we    = 1'b0;
        size_waddr = k_reg;
        size_wdata = cnt_reg[11:0];
        if (state_reg == S_EXEC && realloc_go) begin
            size_we = 1'b1;
        end else if (state_reg == S_SCAN && chunk_free) begin
            size_we    = 1'b1;
            size_waddr = alloc_n;
        end
    end

    assign sav_we = (state_reg == S_SAVE);

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd <= size_mem[size_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sav_we) begin
            sav_mem[{k_reg, wc_reg}] <= wm_reg[wc_reg];
        end
        sav_rd <= sav_mem[{k_reg, wc_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            frame_segment_reg <= 16'(empm_pkg::FRAME_SEG_RESET);
            total_pages_reg   <= 12'(TOTAL_RESET);
            pages_free_reg    <= 12'(TOTAL_RESET);
            open_handles_reg  <= 8'd0;
            in_use_reg        <= '0;
            ctx_reg           <= '0;
            for (int i = 0; i < empm_pkg::WINDOWS; i++) begin
                wm_reg[i] <= '0;
            end
            m_tvalid_reg      <= 1'b0;
            wc_reg            <= 2'd0;
            chunk_reg         <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_addr == empm_pkg::CFG_FRAME_SEGMENT) begin
                    frame_segment_reg <= cfg_wdata;
                end else begin
                    total_pages_reg <= cfg_total;
                    if (open_handles_reg == 8'd0) begin
                        pages_free_reg <= cfg_total;
                    end
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= s_tdata[2:0];
                        addr_reg       <= s_tdata[22:3];
                        lp_reg         <= s_tdata[54:39];
                        win_reg        <= s_tdata[62:55];
                        cnt_reg        <= s_tdata[78:63];
                        k_ok_reg       <= s_k_ok;
                        k_reg          <= s_hm1[HW-1:0];
                        r_status_reg   <= empm_pkg::ST_OK;
                        r_in_frame_reg <= 1'b0;
                        r_mapped_reg   <= 1'b0;
                        r_thandle_reg  <= 8'd0;
                        r_tpage_reg    <= 11'd0;
                        r_poff_reg     <= 14'd0;
                        r_hpages_reg   <= 12'd0;
                        wc_reg         <= 2'd0;
                        chunk_reg      <= '0;
                        state_reg      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    if (op_reg == empm_pkg::OP_ACCESS) begin
                        if (dec.in_frame) begin
                            r_in_frame_reg <= 1'b1;
                            if (wm_reg[dec.win].valid) begin
                                r_mapped_reg  <= 1'b1;
                                r_thandle_reg <= wm_reg[dec.win].handle;
                                r_tpage_reg   <= wm_reg[dec.win].page;
                                r_poff_reg    <= dec.offset;
                                state_reg     <= S_ACC;
                            end
                        end
                    end else if (op_reg == empm_pkg::OP_ALLOC) begin
                        if (cnt_reg > {4'd0, total_pages_reg}) begin
                            r_status_reg <= empm_pkg::ST_OVER_TOTAL;
                        end else if (cnt_reg > {4'd0, pages_free_reg}) begin
                            r_status_reg <= empm_pkg::ST_OVER_FREE;
                        end else if (cnt_reg == 16'd0) begin
                            r_status_reg <= empm_pkg::ST_ZERO;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end else if (!k_ok_reg) begin
                        r_status_reg <= empm_pkg::ST_NO_HANDLE;
                    end else begin
                        // A successful release reports no pages, a resize the new count.
                        if (op_reg == empm_pkg::OP_RELEASE && !ctx_reg[k_reg]) begin
                            r_hpages_reg <= 12'd0;
                        end else if (realloc_go) begin
                            r_hpages_reg <= cnt_reg[11:0];
                        end else begin
                            r_hpages_reg <= size_rd;
                        end
                        unique case (op_reg)
                            empm_pkg::OP_RELEASE: begin
                                if (ctx_reg[k_reg]) begin
                                    r_status_reg <= empm_pkg::ST_CTX_SAVED;
                                end else begin
                                    pages_free_reg   <= pages_free_reg + size_rd;
                                    in_use_reg[k_reg] <= 1'b0;
                                    open_handles_reg <= open_handles_reg - 8'd1;
                                    state_reg        <= S_CHK_RD;
                                end
                            end
                            empm_pkg::OP_MAP: begin
                                if (lp_reg != empm_pkg::UNMAP_PAGE
                                        && lp_reg >= {4'd0, size_rd}) begin
                                    r_status_reg <= empm_pkg::ST_BAD_LOGICAL;
                                end else if (win_reg >= 8'(empm_pkg::WINDOWS)) begin
                                    r_status_reg <= empm_pkg::ST_BAD_WINDOW;
                                end else if (lp_reg == empm_pkg::UNMAP_PAGE) begin
                                    wm_reg[win_reg[1:0]] <= '0;
                                end else begin
                                    wm_reg[win_reg[1:0]].valid  <= 1'b1;
                                    wm_reg[win_reg[1:0]].handle <= 8'(k_reg) + 8'd1;
                                    wm_reg[win_reg[1:0]].page   <= lp_reg[10:0];
                                end
                            end
                            empm_pkg::OP_SAVE: begin
                                if (ctx_reg[k_reg]) begin
                                    r_status_reg <= empm_pkg::ST_SAVE_USED;
                                end else begin
                                    state_reg <= S_CHK_RD;
                                end
                            end
                            empm_pkg::OP_RESTORE: begin
                                if (!ctx_reg[k_reg]) begin
                                    r_status_reg <= empm_pkg::ST_SAVE_UNUSED;
                                end else begin
                                    ctx_reg[k_reg] <= 1'b0;
                                    state_reg      <= S_RST_RD;
                                end
                            end
                            empm_pkg::OP_REALLOC: begin
                                if (cnt_reg == {4'd0, size_rd}) begin
                                    r_status_reg <= empm_pkg::ST_OK;
                                end else if (cnt_reg > {4'd0, total_pages_reg}) begin
                                    r_status_reg <= empm_pkg::ST_OVER_TOTAL;
                                end else if (cnt_reg > {3'd0, avail}) begin
                                    r_status_reg <= empm_pkg::ST_OVER_FREE;
                                end else begin
                                    pages_free_reg <= 12'(avail - cnt_reg[12:0]);
                                    state_reg      <= S_CHK_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ACC: begin
                    r_hpages_reg <= acc_h_ok ? size_rd : 12'd0;
                    state_reg    <= S_DONE;
                end
                S_SCAN: begin
                    if (chunk_free) begin
                        in_use_reg[alloc_n] <= 1'b1;
                        ctx_reg[alloc_n]    <= 1'b0;
                        pages_free_reg      <= pages_free_reg - cnt_reg[11:0];
                        open_handles_reg    <= open_handles_reg + 8'd1;
                        r_thandle_reg       <= 8'(alloc_n) + 8'd1;
                        r_hpages_reg        <= cnt_reg[11:0];
                        state_reg           <= S_DONE;
                    end else if (32'(chunk_reg) == NCH - 1) begin
                        r_status_reg <= empm_pkg::ST_EXHAUSTED;
                        state_reg    <= S_DONE;
                    end else begin
                        chunk_reg <= chunk_reg + CW'(1);
                    end
                end
                S_CHK_RD: begin
                    state_reg <= S_CHK_CMP;
                end
                S_CHK_CMP: begin
                    if (wm_reg[wc_reg].valid
                            && !(chk_h_ok && {1'b0, wm_reg[wc_reg].page} < size_rd)) begin
                        wm_reg[wc_reg] <= '0;
                    end
                    wc_reg <= wc_reg + 2'd1;
                    if (wc_reg == 2'd3) begin
                        state_reg <= (op_reg == empm_pkg::OP_SAVE) ? S_SAVE : S_DONE;
                    end else begin
                        state_reg <= S_CHK_RD;
                    end
                end
                S_SAVE: begin
                    wc_reg <= wc_reg + 2'd1;
                    if (wc_reg == 2'd3) begin
                        ctx_reg[k_reg] <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                end
                S_RST_RD: begin
                    state_reg <= S_RST_WR;
                end
                S_RST_WR: begin
                    wm_reg[wc_reg] <= sav_rd;
                    wc_reg         <= wc_reg + 2'd1;
                    state_reg      <= (wc_reg == 2'd3) ? S_CHK_RD : S_RST_RD;
                end
                S_DONE: begin
                    // Hold the result until the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{1'b0, open_handles_reg} + 9'd1, pages_free_reg,
                                         r_hpages_reg, r_poff_reg, r_tpage_reg,
                                         r_thandle_reg, r_mapped_reg, r_in_frame_reg,
                                         r_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_open_count : assert property (@(posedge aclk) disable iff (!aresetn)
        32'(open_handles_reg) == $countones(in_use_reg))
        else $error("open handle count disagrees with handle flags");

    a_win_handle : assert property (@(posedge aclk) disable iff (!aresetn)
        (!wm_reg[0].valid || wm_reg[0].handle != 8'd0) &&
        (!wm_reg[1].valid || wm_reg[1].handle != 8'd0) &&
        (!wm_reg[2].valid || wm_reg[2].handle != 8'd0) &&
        (!wm_reg[3].valid || wm_reg[3].handle != 8'd0))
        else $error("mapped window names handle zero");

    a_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a transfer is being processed");

endmodule

### verif/tb.sv
// Self-checking testbench for the expanded memory page mapper core.
module tb;

    // Fields are listed from the highest bits down so that the last field
    // lands in the lowest bits of the bus.
    typedef struct packed {
        logic [15:0] page_count;
        logic [7:0]  window;
        logic [15:0] logical_page;
        logic [15:0] handle_in;
        logic [19:0] address;
        logic [2:0]  op;
    } request_t;

    typedef struct packed {
        logic [8:0]  handle_count;
        logic [11:0] free_pages;
        logic [11:0] handle_pages;
        logic [13:0] page_offset;
        logic [10:0] target_page;
        logic [7:0]  target_handle;
        logic        mapped;
        logic        in_frame;
        logic [3:0]  status;
    } result_t;

    localparam int NHANDLES = empm_pkg::HANDLES_DEF;
    localparam int LIMIT_CYCLES = 1500000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [empm_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [empm_pkg::OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;

    expanded_memory_page_mapper_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Mirror of the mapper state.
    logic [15:0] mir_segment;
    logic [11:0] mir_total;
    logic        mir_used [NHANDLES];
    logic [11:0] mir_size [NHANDLES];
    logic        mir_saved [NHANDLES];
    empm_pkg::win_t mir_ctx [NHANDLES][empm_pkg::WINDOWS];
    empm_pkg::win_t mir_win [empm_pkg::WINDOWS];
    logic [11:0] mir_free;
    int          mir_open;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  send_hold = 1'b0;
    longint cycles = 0;

    function automatic int lookup_handle(logic [15:0] h);
        if (h < 1 || h > NHANDLES) return -1;
        if (!mir_used[h-1]) return -1;
        return h - 1;
    endfunction

    function automatic void prune_windows();
        int k;
        for (int i = 0; i < empm_pkg::WINDOWS; i++) begin
            if (mir_win[i].valid) begin
                k = lookup_handle({8'd0, mir_win[i].handle});
                if (k < 0 || {1'b0, mir_win[i].page} >= mir_size[k]) mir_win[i] = '0;
            end
        end
    endfunction

    function automatic void mapper_reset();
        mir_segment = 16'(empm_pkg::FRAME_SEG_RESET);
        mir_total = 12'd2048;
        for (int i = 0; i < NHANDLES; i++) begin
            mir_used[i] = 0; mir_size[i] = 0; mir_saved[i] = 0;
        end
        for (int i = 0; i < empm_pkg::WINDOWS; i++) mir_win[i] = '0;
        mir_free = mir_total;
        mir_open = 0;
    endfunction

    function automatic result_t translate(request_t rq);
        result_t r;
        int k;
        int n;
        int base;
        int off;
        int wi;
        int avail;
        r = '0;
        k = -1;
        if (rq.op != empm_pkg::OP_ACCESS && rq.op != empm_pkg::OP_ALLOC) begin
            k = lookup_handle(rq.handle_in);
            if (k < 0) r.status = empm_pkg::ST_NO_HANDLE;
        end
        case (empm_pkg::op_t'(rq.op))
            empm_pkg::OP_ACCESS: begin
                base = int'(mir_segment) << 4;
                if (int'(rq.address) >= base && int'(rq.address) < base + 'h10000) begin
                    off = int'(rq.address) - base;
                    wi = (off / empm_pkg::PAGE_BYTES) % empm_pkg::WINDOWS;
                    r.in_frame = 1;
                    if (mir_win[wi].valid) begin
                        r.mapped = 1;
                        r.target_handle = mir_win[wi].handle;
                        r.target_page = mir_win[wi].page;
                        r.page_offset = 14'(off % empm_pkg::PAGE_BYTES);
                        n = lookup_handle({8'd0, mir_win[wi].handle});
                        if (n >= 0) r.handle_pages = mir_size[n];
                    end
                end
            end
            empm_pkg::OP_ALLOC: begin
                if (rq.page_count > mir_total) r.status = empm_pkg::ST_OVER_TOTAL;
                else if (rq.page_count > mir_free) r.status = empm_pkg::ST_OVER_FREE;
                else if (rq.page_count == 0) r.status = empm_pkg::ST_ZERO;
                else begin
                    n = -1;
                    for (int i = 0; i < NHANDLES; i++)
                        if (n < 0 && !mir_used[i]) n = i;
                    if (n < 0) r.status = empm_pkg::ST_EXHAUSTED;
                    else begin
                        mir_used[n] = 1;
                        mir_size[n] = 12'(rq.page_count);
                        mir_saved[n] = 0;
                        mir_free = mir_free - 12'(rq.page_count);
                        mir_open++;
                        r.target_handle = 8'(n + 1);
                        r.handle_pages = 12'(rq.page_count);
                    end
                end
            end
            default: begin
                if (k >= 0) begin
                    r.handle_pages = mir_size[k];
                    case (empm_pkg::op_t'(rq.op))
                        empm_pkg::OP_RELEASE: begin
                            if (mir_saved[k]) r.status = empm_pkg::ST_CTX_SAVED;
                            else begin
                                mir_free = mir_free + mir_size[k];
                                mir_used[k] = 0;
                                mir_size[k] = 0;
                                mir_open--;
                                r.handle_pages = 0;
                                prune_windows();
                            end
                        end
                        empm_pkg::OP_MAP: begin
                            if (rq.logical_page != empm_pkg::UNMAP_PAGE
                                    && rq.logical_page >= mir_size[k])
                                r.status = empm_pkg::ST_BAD_LOGICAL;
                            else if (rq.window >= empm_pkg::WINDOWS)
                                r.status = empm_pkg::ST_BAD_WINDOW;
                            else begin
                                mir_win[rq.window] = '0;
                                if (rq.logical_page != empm_pkg::UNMAP_PAGE) begin
                                    mir_win[rq.window].valid = 1;
                                    mir_win[rq.window].handle = 8'(k + 1);
                                    mir_win[rq.window].page = 11'(rq.logical_page);
                                end
                            end
                        end
                        empm_pkg::OP_SAVE: begin
                            if (mir_saved[k]) r.status = empm_pkg::ST_SAVE_USED;
                            else begin
                                prune_windows();
                                for (int i = 0; i < empm_pkg::WINDOWS; i++)
                                    mir_ctx[k][i] = mir_win[i];
                                mir_saved[k] = 1;
                            end
                        end
                        empm_pkg::OP_RESTORE: begin
                            if (!mir_saved[k]) r.status = empm_pkg::ST_SAVE_UNUSED;
                            else begin
                                mir_saved[k] = 0;
                                for (int i = 0; i < empm_pkg::WINDOWS; i++)
                                    mir_win[i] = mir_ctx[k][i];
                                prune_windows();
                            end
                        end
                        empm_pkg::OP_REALLOC: begin
                            avail = int'(mir_free) + int'(mir_size[k]);
                            if (rq.page_count == mir_size[k]) r.status = empm_pkg::ST_OK;
                            else if (rq.page_count > mir_total)
                                r.status = empm_pkg::ST_OVER_TOTAL;
                            else if (int'(rq.page_count) > avail)
                                r.status = empm_pkg::ST_OVER_FREE;
                            else begin
                                mir_free = 12'(avail - int'(rq.page_count));
                                mir_size[k] = 12'(rq.page_count);
                                r.handle_pages = 12'(rq.page_count);
                                prune_windows();
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        r.free_pages = mir_free;
        r.handle_count = 9'(mir_open + 1);
        return r;
    endfunction

    // Driver.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= {1'b0, pending_requests.pop_front()} ;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The prediction is made when the request transfer happens.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(translate(request_t'(s_tdata[78:0])));
    end

    // Monitor.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status); errors++;
                end
                if (got.in_frame !== want.in_frame) begin
                    $display("%0t: in_frame exp %0d got %0d", $time, want.in_frame, got.in_frame); errors++;
                end
                if (got.mapped !== want.mapped) begin
                    $display("%0t: mapped exp %0d got %0d", $time, want.mapped, got.mapped); errors++;
                end
                if (got.target_handle !== want.target_handle) begin
                    $display("%0t: target_handle exp %0d got %0d", $time,
                             want.target_handle, got.target_handle); errors++;
                end
                if (got.target_page !== want.target_page) begin
                    $display("%0t: target_page exp %0d got %0d", $time,
                             want.target_page, got.target_page); errors++;
                end
                if (got.page_offset !== want.page_offset) begin
                    $display("%0t: page_offset exp %0d got %0d", $time,
                             want.page_offset, got.page_offset); errors++;
                end
                if (got.handle_pages !== want.handle_pages) begin
                    $display("%0t: handle_pages exp %0d got %0d", $time,
                             want.handle_pages, got.handle_pages); errors++;
                end
                if (got.free_pages !== want.free_pages) begin
                    $display("%0t: free_pages exp %0d got %0d", $time,
                             want.free_pages, got.free_pages); errors++;
                end
                if (got.handle_count !== want.handle_count) begin
                    $display("%0t: handle_count exp %0d got %0d", $time,
                             want.handle_count, got.handle_count); errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic request_t make_request(empm_pkg::op_t op, logic [19:0] a,
                                              logic [15:0] h, logic [15:0] lp,
                                              logic [7:0] w, logic [15:0] cnt);
        request_t rq;
        rq.op = op; rq.address = a; rq.handle_in = h;
        rq.logical_page = lp; rq.window = w; rq.page_count = cnt;
        return rq;
    endfunction

    // Mostly sensible commands: small handle numbers, counts and pages near the sizes.
    function automatic request_t random_request();
        request_t rq;
        int sel;
        rq = request_t'({$urandom, $urandom, $urandom});
        sel = $urandom_range(99);
        if (sel < 35) rq.op = empm_pkg::OP_ACCESS;
        else rq.op = 3'($urandom_range(7));
        if ($urandom_range(9) < 7)
            rq.address = 20'((int'(mir_segment) << 4) + $urandom_range(16'hffff));
        if ($urandom_range(9) < 8) rq.handle_in = 16'($urandom_range(12));
        if ($urandom_range(9) < 7) rq.logical_page = 16'($urandom_range(40));
        else if ($urandom_range(3) == 0) rq.logical_page = empm_pkg::UNMAP_PAGE;
        if ($urandom_range(9) < 8) rq.window = 8'($urandom_range(empm_pkg::WINDOWS - 1));
        if ($urandom_range(9) < 8) rq.page_count = 16'($urandom_range(60));
        else if ($urandom_range(1) == 0) rq.page_count = 16'($urandom_range(2100));
        return rq;
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge aclk);
        cfg_addr <= idx;
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == empm_pkg::CFG_FRAME_SEGMENT) mir_segment = val;
        else begin
            mir_total = (val[11:0] > 12'd2048) ? 12'd2048 : val[11:0];
            if (mir_open == 0) mir_free = mir_total;
        end
    endtask

    task automatic random_phase(int n, int sp, int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int i = 0; i < n; i++) begin
            pending_requests.push_back(random_request());
            // Fill lazily so that address choices track the current segment.
            while (pending_requests.size() > 8) @(posedge aclk);
        end
        wait_idle();
    endtask

    initial begin
        mapper_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every operation, field extremes, error codes.
        pending_requests.push_back(make_request(empm_pkg::OP_ACCESS, 20'he0000, 0, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ACCESS, 20'hfffff, 0, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ACCESS, 20'h00000, 0, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 16'hffff));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 16'd2048));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 16'd1));
        pending_requests.push_back(make_request(empm_pkg::OP_RELEASE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 16'd8));
        pending_requests.push_back(make_request(empm_pkg::OP_ALLOC, 0, 0, 0, 0, 16'd4));
        pending_requests.push_back(make_request(empm_pkg::OP_MAP, 0, 1, 16'd7, 8'd3, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_MAP, 0, 2, 16'd3, 8'd0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_MAP, 0, 1, 16'd8, 8'd1, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_MAP, 0, 1, 16'd0, 8'hff, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_ACCESS, 20'hfffff, 0, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_SAVE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_SAVE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_RELEASE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_REALLOC, 0, 1, 0, 0, 16'd2));
        pending_requests.push_back(make_request(empm_pkg::OP_MAP, 0, 1,
                                                empm_pkg::UNMAP_PAGE, 8'd3, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_RESTORE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_RESTORE, 0, 1, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_QUERY, 0, 16'hffff, 0, 0, 0));
        pending_requests.push_back(make_request(empm_pkg::OP_REALLOC, 0, 2, 0, 0, 16'hffff));
        pending_requests.push_back(make_request(empm_pkg::OP_QUERY, 0, 2, 0, 0, 0));
        wait_idle();

        random_phase(600, 28, 61);
        // Pause the sender until everything has drained, then resume.
        send_hold = 1'b1;
        pending_requests.push_back(random_request());
        while (expected_results.size() > 0 || s_tvalid) @(posedge aclk);
        send_hold = 1'b0;
        wait_idle();

        write_reg(empm_pkg::CFG_FRAME_SEGMENT, 16'hf000);
        write_reg(empm_pkg::CFG_TOTAL_PAGES, 16'h0fff);
        random_phase(300, 61, 28);
        write_reg(empm_pkg::CFG_FRAME_SEGMENT, 16'h0000);
        write_reg(empm_pkg::CFG_TOTAL_PAGES, 16'h0000);
        random_phase(200, 61, 28);
        write_reg(empm_pkg::CFG_FRAME_SEGMENT, 16'hffff);
        write_reg(empm_pkg::CFG_TOTAL_PAGES, 16'd100);
        random_phase(200, 0, 0);
        write_reg(empm_pkg::CFG_FRAME_SEGMENT, 16'h8a40);
        write_reg(empm_pkg::CFG_TOTAL_PAGES, 16'd2048);
        random_phase(550, 0, 0);

        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
